### design/uart_frame_receiver_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the frame receiver
// Shared forms for the concurrent checks used in the design modules.
// ---------------------------------------------------------------------------
`ifndef UART_FRAME_RECEIVER_MACROS_SVH
`define UART_FRAME_RECEIVER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define UFR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent.
`define UFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/ufr_pkg.sv
// ---------------------------------------------------------------------------
// Frame receiver package
// Types, codes and CRC byte-update functions shared by the receiver modules.
// ---------------------------------------------------------------------------
`default_nettype none
package ufr_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

   localparam logic [7:0] StartByte  = 8'h53;
   localparam logic [7:0] MagicByte  = 8'h42;
   localparam logic [15:0] Crc16Poly = 16'h1021;
   localparam logic [31:0] Crc32Poly = 32'hedb88320;

   localparam logic [0:0] CsrVersion = 1'b0;
   localparam logic [0:0] CsrMaxLen  = 1'b1;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_END     = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_MAGIC    = 3'd1,
      ST_HDR_CRC  = 3'd2,
      ST_VER_LEN  = 3'd3,
      ST_PLD_CRC  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'b0001,
      PH_HEADER  = 4'b0010,
      PH_PAYLOAD = 4'b0100,
      PH_PCRC    = 4'b1000
   } phase_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] pkt_type;
      logic [7:0] pkt_flags;
      logic [15:0] seq_num;
      logic [31:0] session;
      logic [31:0] byte_offset;
      logic [15:0] payload_len;
      logic [7:0] payload_byte;
      status_type status;
      logic       last;
   } result_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ Crc16Poly) : (c << 1);
      end
      return c;
   endfunction

   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ Crc32Poly) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

### design/ufr_front.sv
// ---------------------------------------------------------------------------
// Frame receiver front end
// Tracks frame phase, collects and checks header and payload, forms results.
// ---------------------------------------------------------------------------
`default_nettype none
module ufr_front import ufr_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       byte_valid,
   input  wire logic [7:0] byte_data,
   input  wire logic [7:0] version_cfg,
   input  wire logic [15:0] max_len_cfg,
   output result_type      res,
   output logic            res_valid
);

   phase_type   phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  hdr_ff [2:17];
   logic [15:0] hcrc_ff, hcrc_in;
   logic [7:0]  rxcrc_lo_ff;
   logic [31:0] pcrc_ff, pcrc_in;
   logic [23:0] rxp_ff;
   logic [15:0] len_ff, len_in;
   logic [15:0] hdr_len;

   assign hdr_len = {hdr_ff[17], hdr_ff[16]};

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      hcrc_in   = hcrc_ff;
      pcrc_in   = pcrc_ff;
      len_in    = len_ff;
      res       = '0;
      res_valid = 1'b0;
      if (byte_valid) begin
         case (phase_ff)
            PH_HUNT: begin
               if (byte_data == StartByte) begin
                  hcrc_in  = crc16_byte(16'hffff, byte_data);
                  count_in = 16'd1;
                  phase_in = PH_HEADER;
               end
            end
            PH_HEADER: begin
               if (count_ff == 16'd1 && byte_data != MagicByte) begin
                  res.kind   = KIND_END;
                  res.status = ST_MAGIC;
                  res.last   = 1'b1;
                  res_valid  = 1'b1;
                  phase_in   = PH_HUNT;
                  count_in   = '0;
               end else if (count_ff < 16'd18) begin
                  hcrc_in  = crc16_byte(hcrc_ff, byte_data);
                  count_in = count_ff + 16'd1;
               end else if (count_ff == 16'd18) begin
                  hcrc_in  = crc16_byte(hcrc_ff, 8'h00);
                  count_in = count_ff + 16'd1;
               end else begin
                  hcrc_in   = crc16_byte(hcrc_ff, 8'h00);
                  res_valid = 1'b1;
                  count_in  = '0;
                  if (hcrc_in != {byte_data, rxcrc_lo_ff}) begin
                     res.kind   = KIND_END;
                     res.status = ST_HDR_CRC;
                     res.last   = 1'b1;
                     phase_in   = PH_HUNT;
                  end else if (hdr_ff[2] != version_cfg || hdr_len > max_len_cfg) begin
                     res.kind   = KIND_END;
                     res.status = ST_VER_LEN;
                     res.last   = 1'b1;
                     phase_in   = PH_HUNT;
                  end else begin
                     res.kind        = KIND_HEADER;
                     res.pkt_type    = hdr_ff[3];
                     res.pkt_flags   = hdr_ff[4];
                     res.seq_num     = {hdr_ff[7], hdr_ff[6]};
                     res.session     = {hdr_ff[11], hdr_ff[10], hdr_ff[9], hdr_ff[8]};
                     res.byte_offset = {hdr_ff[15], hdr_ff[14], hdr_ff[13], hdr_ff[12]};
                     res.payload_len = hdr_len;
                     len_in          = hdr_len;
                     pcrc_in         = 32'hffffffff;
                     phase_in        = (hdr_len == 16'd0) ? PH_PCRC : PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               pcrc_in          = crc32_byte(pcrc_ff, byte_data);
               count_in         = count_ff + 16'd1;
               res.kind         = KIND_PAYLOAD;
               res.payload_byte = byte_data;
               res_valid        = 1'b1;
               if (count_in >= len_ff) begin
                  count_in = '0;
                  phase_in = PH_PCRC;
               end
            end
            PH_PCRC: begin
               if (count_ff[1:0] != 2'd3) begin
                  count_in = {14'd0, count_ff[1:0] + 2'd1};
               end else begin
                  res.kind   = KIND_END;
                  res.status = (~pcrc_ff == {byte_data, rxp_ff}) ? ST_OK : ST_PLD_CRC;
                  res.last   = 1'b1;
                  res_valid  = 1'b1;
                  phase_in   = PH_HUNT;
                  count_in   = '0;
               end
            end
            default: begin
               phase_in = PH_HUNT;
               count_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
      hcrc_ff <= hcrc_in;
      pcrc_ff <= pcrc_in;
      len_ff  <= len_in;
      if (byte_valid && phase_ff == PH_HEADER) begin
         for (int p = 2; p <= 17; p++) begin
            if (count_ff == 16'(p)) begin
               hdr_ff[p] <= byte_data;
            end
         end
         if (count_ff == 16'd18) begin
            rxcrc_lo_ff <= byte_data;
         end
      end
      if (byte_valid && phase_ff == PH_PCRC) begin
         case (count_ff[1:0])
            2'd0:    rxp_ff[7:0]   <= byte_data;
            2'd1:    rxp_ff[15:8]  <= byte_data;
            2'd2:    rxp_ff[23:16] <= byte_data;
            default: ;
         endcase
      end
   end

`include "uart_frame_receiver_macros.svh"
   `UFR_ASSERT_IMP(a_end_is_last, clock, reset, res_valid, (res.last == (res.kind == KIND_END)), "last flag does not match end result")
   `UFR_ASSERT_NEXT(a_end_to_hunt, clock, reset, res_valid && res.last, phase_ff == PH_HUNT, "frame end did not return to hunting")
   `UFR_ASSERT_IMP(a_pcrc_count, clock, reset, phase_ff == PH_PCRC, count_ff < 16'd4, "payload crc count out of range")

endmodule
`default_nettype wire

### design/ufr_queue.sv
// ---------------------------------------------------------------------------
// Frame receiver result queue
// Small queue that decouples result forming from the consumer.
// ---------------------------------------------------------------------------
`default_nettype none
module ufr_queue import ufr_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       wr_en,
   input  wire result_type wr_data,
   input  wire logic       rd_en,
   output result_type      rd_data,
   output logic            full,
   output logic            empty
);

   result_type           mem_ff [QueueDepth];
   logic [QueuePtrW-1:0] wptr_ff, rptr_ff;
   logic [QueuePtrW:0]   cnt_ff;

   assign full    = (cnt_ff == (QueuePtrW+1)'(QueueDepth));
   assign empty   = (cnt_ff == '0);
   assign rd_data = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (wr_en) wptr_ff <= wptr_ff + 1'b1;
         if (rd_en) rptr_ff <= rptr_ff + 1'b1;
         cnt_ff <= cnt_ff + {{QueuePtrW{1'b0}}, wr_en} - {{QueuePtrW{1'b0}}, rd_en};
      end
      if (wr_en) mem_ff[wptr_ff] <= wr_data;
   end

`include "uart_frame_receiver_macros.svh"
   `UFR_ASSERT_IMP(a_no_overflow, clock, reset, wr_en && !rd_en, !full, "write into full queue")
   `UFR_ASSERT_IMP(a_no_underflow, clock, reset, rd_en, !empty, "read from empty queue")
   `UFR_ASSERT_IMP(a_ptr_count, clock, reset, 1'b1, (QueuePtrW'(cnt_ff) == QueuePtrW'(wptr_ff - rptr_ff)), "pointer difference disagrees with count")

endmodule
`default_nettype wire

### design/uart_frame_receiver.sv
// ---------------------------------------------------------------------------
// UART frame receiver
// Deframes CRC-checked packets from a byte stream.
// ---------------------------------------------------------------------------
// One received byte is accepted per clock when full is low. The front end
// checks and classifies each byte in the cycle it arrives; any result is
// written into a four-entry queue at the end of that cycle and reaches the
// rsp_ ports once it is at the queue head. The header CRC and payload CRC
// are each updated a byte per cycle when one is accepted, by one unrolled
// bit loop. full is raised only when the queue holds four unread results.
`default_nettype none
module uart_frame_receiver import ufr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_rx_byte,
   output logic             empty,
   input  wire logic        pop,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_pkt_type,
   output logic [7:0]       rsp_pkt_flags,
   output logic [15:0]      rsp_seq_num,
   output logic [31:0]      rsp_session,
   output logic [31:0]      rsp_byte_offset,
   output logic [15:0]      rsp_payload_len,
   output logic [7:0]       rsp_payload_byte,
   output logic [2:0]       rsp_status,
   output logic             rsp_last,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   logic [7:0]  version_ff;
   logic [15:0] max_len_ff;
   result_type  res, head;
   logic        res_valid, accept;

   assign accept = push && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= 8'd1;
         max_len_ff <= 16'd1024;
      end else if (csr_we) begin
         case (csr_index)
            CsrVersion: version_ff <= csr_wdata[7:0];
            CsrMaxLen:  max_len_ff <= csr_wdata;
            default:    ;
         endcase
      end
   end

   ufr_front u_front (
      .clock, .reset,
      .byte_valid (accept),
      .byte_data  (req_rx_byte),
      .version_cfg(version_ff),
      .max_len_cfg(max_len_ff),
      .res, .res_valid
   );

   ufr_queue u_queue (
      .clock, .reset,
      .wr_en  (res_valid),
      .wr_data(res),
      .rd_en  (pop && !empty),
      .rd_data(head),
      .full, .empty
   );

   assign rsp_kind         = head.kind;
   assign rsp_pkt_type     = head.pkt_type;
   assign rsp_pkt_flags    = head.pkt_flags;
   assign rsp_seq_num      = head.seq_num;
   assign rsp_session      = head.session;
   assign rsp_byte_offset  = head.byte_offset;
   assign rsp_payload_len  = head.payload_len;
   assign rsp_payload_byte = head.payload_byte;
   assign rsp_status       = head.status;
   assign rsp_last         = head.last;

endmodule
`default_nettype wire

### sim/testbench.sv
// ---------------------------------------------------------------------------
// Frame receiver testbench
// Sends noise and whole frames, both good and damaged, into the receiver
// under several register settings, with random gaps on both sides. It
// predicts every header, payload and end-of-frame result and checks each
// popped result against the oldest prediction, field by field.
// ---------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ufr_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int PatRandom = 0;
   localparam int PatZeros  = 1;
   localparam int PatOnes   = 2;
   localparam int FaultNone    = 0;
   localparam int FaultMagic   = 1;
   localparam int FaultHdrCrc  = 2;
   localparam int FaultPldCrc  = 3;
   localparam int FaultVersion = 4;
   localparam int FaultLength  = 5;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_rx_byte = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_pkt_type;
   logic [7:0]  rsp_pkt_flags;
   logic [15:0] rsp_seq_num;
   logic [31:0] rsp_session;
   logic [31:0] rsp_byte_offset;
   logic [15:0] rsp_payload_len;
   logic [7:0]  rsp_payload_byte;
   logic [2:0]  rsp_status;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = CsrVersion;
   logic [15:0] csr_wdata = '0;

   uart_frame_receiver u_dut (.*);

   logic [7:0]  pending_bytes[$];
   result_type  expected_results[$];
   int          fail_count = 0;
   int          cycle_count = 0;
   int          results_seen = 0;
   int          stall_left = 0;
   bit          stall_done = 1'b0;

   logic [7:0]  cfg_version = 8'd1;
   logic [15:0] cfg_max_len = 16'd1024;

   phase_type   rx_phase = PH_HUNT;
   logic [15:0] rx_count = '0;
   logic [7:0]  rx_hdr[2:17];
   logic [15:0] rx_hcrc_acc = 16'hffff;
   logic [15:0] rx_hcrc_got = '0;
   logic [31:0] rx_pcrc_acc = 32'hffffffff;
   logic [31:0] rx_pcrc_got = '0;
   logic [15:0] rx_len = '0;

   always #5 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("testbench failed");
         $finish;
      end
   end

   function automatic logic [15:0] ccitt_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      return c;
   endfunction

   function automatic logic [31:0] ieee_next(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hedb88320) : (c >> 1);
      return c;
   endfunction

   function automatic bit gap_now();
      if ((cycle_count % 25000) < 4000) return 1'b0;
      return $urandom_range(99) < 32;
   endfunction

   task automatic close_frame(input status_type st);
      result_type r;
      r = '0;
      r.kind = KIND_END;
      r.status = st;
      r.last = 1'b1;
      expected_results.push_back(r);
      rx_phase = PH_HUNT;
      rx_count = '0;
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      result_type r;
      logic [15:0] len_v;
      r = '0;
      case (rx_phase)
         PH_HUNT: begin
            if (b == StartByte) begin
               rx_hcrc_acc = ccitt_next(16'hffff, b);
               rx_hcrc_got = '0;
               rx_count = 16'd1;
               rx_phase = PH_HEADER;
            end
         end
         PH_HEADER: begin
            if (rx_count == 1 && b != MagicByte) begin
               close_frame(ST_MAGIC);
            end else begin
               if (rx_count <= 17) begin
                  if (rx_count >= 2) rx_hdr[rx_count] = b;
                  rx_hcrc_acc = ccitt_next(rx_hcrc_acc, b);
               end else begin
                  if (rx_count == 18) rx_hcrc_got = {8'h00, b};
                  else rx_hcrc_got[15:8] = b;
                  rx_hcrc_acc = ccitt_next(rx_hcrc_acc, 8'h00);
               end
               if (rx_count < 19) begin
                  rx_count = rx_count + 1;
               end else if (rx_hcrc_acc != rx_hcrc_got) begin
                  close_frame(ST_HDR_CRC);
               end else begin
                  len_v = {rx_hdr[17], rx_hdr[16]};
                  if (rx_hdr[2] != cfg_version || len_v > cfg_max_len) begin
                     close_frame(ST_VER_LEN);
                  end else begin
                     r.kind = KIND_HEADER;
                     r.pkt_type = rx_hdr[3];
                     r.pkt_flags = rx_hdr[4];
                     r.seq_num = {rx_hdr[7], rx_hdr[6]};
                     r.session = {rx_hdr[11], rx_hdr[10], rx_hdr[9], rx_hdr[8]};
                     r.byte_offset = {rx_hdr[15], rx_hdr[14], rx_hdr[13], rx_hdr[12]};
                     r.payload_len = len_v;
                     expected_results.push_back(r);
                     rx_pcrc_acc = 32'hffffffff;
                     rx_pcrc_got = '0;
                     rx_count = '0;
                     rx_len = len_v;
                     rx_phase = (len_v == 0) ? PH_PCRC : PH_PAYLOAD;
                  end
               end
            end
         end
         PH_PAYLOAD: begin
            rx_pcrc_acc = ieee_next(rx_pcrc_acc, b);
            rx_count = rx_count + 1;
            r.kind = KIND_PAYLOAD;
            r.payload_byte = b;
            expected_results.push_back(r);
            if (rx_count >= rx_len) begin
               rx_count = '0;
               rx_phase = PH_PCRC;
            end
         end
         default: begin
            rx_pcrc_got[8 * rx_count[1:0] +: 8] = b;
            if (rx_count[1:0] < 2'd3) rx_count = rx_count + 1;
            else close_frame((~rx_pcrc_acc == rx_pcrc_got) ? ST_OK : ST_PLD_CRC);
         end
      endcase
   endtask

   // Sender: holds a request until it is taken, then maybe inserts a gap.
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) deframe_byte(req_rx_byte);
         if (push && full) begin
            push <= 1'b1;
         end else if (pending_bytes.size() != 0 && !gap_now()) begin
            push <= 1'b1;
            req_rx_byte <= pending_bytes.pop_front();
         end else begin
            push <= 1'b0;
         end
      end
   end

   // Receiver: checks each popped result; stalls at random and once at length.
   always @(posedge clock) begin
      result_type e;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
               $error("unexpected result, kind %0d", rsp_kind);
               fail_count++;
            end else begin
               e = expected_results.pop_front();
               if (rsp_kind !== e.kind) begin
                  $error("kind: expected %0d, actual %0d", e.kind, rsp_kind);
                  fail_count++;
               end
               if (rsp_pkt_type !== e.pkt_type) begin
                  $error("pkt_type: expected %0h, actual %0h", e.pkt_type, rsp_pkt_type);
                  fail_count++;
               end
               if (rsp_pkt_flags !== e.pkt_flags) begin
                  $error("pkt_flags: expected %0h, actual %0h", e.pkt_flags, rsp_pkt_flags);
                  fail_count++;
               end
               if (rsp_seq_num !== e.seq_num) begin
                  $error("seq_num: expected %0h, actual %0h", e.seq_num, rsp_seq_num);
                  fail_count++;
               end
               if (rsp_session !== e.session) begin
                  $error("session: expected %0h, actual %0h", e.session, rsp_session);
                  fail_count++;
               end
               if (rsp_byte_offset !== e.byte_offset) begin
                  $error("byte_offset: expected %0h, actual %0h", e.byte_offset,
                         rsp_byte_offset);
                  fail_count++;
               end
               if (rsp_payload_len !== e.payload_len) begin
                  $error("payload_len: expected %0d, actual %0d", e.payload_len,
                         rsp_payload_len);
                  fail_count++;
               end
               if (rsp_payload_byte !== e.payload_byte) begin
                  $error("payload_byte: expected %0h, actual %0h", e.payload_byte,
                         rsp_payload_byte);
                  fail_count++;
               end
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d, actual %0d", e.status, rsp_status);
                  fail_count++;
               end
               if (rsp_last !== e.last) begin
                  $error("last: expected %0d, actual %0d", e.last, rsp_last);
                  fail_count++;
               end
            end
         end
         if (!stall_done && results_seen >= 100) begin
            stall_done <= 1'b1;
            stall_left <= 400;
            pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            pop <= 1'b0;
         end else begin
            pop <= !gap_now();
         end
      end
   end

   task automatic add_frame(input logic [7:0] ver, input logic [15:0] len,
                            input int fault, input int pat);
      logic [7:0]  h[0:19];
      logic [15:0] hcrc;
      logic [31:0] pcrc;
      logic [7:0]  b;
      h[0] = StartByte;
      h[1] = MagicByte;
      for (int i = 2; i < 18; i++)
         h[i] = (pat == PatZeros) ? 8'h00 : (pat == PatOnes) ? 8'hff : 8'($urandom);
      h[2] = ver;
      h[16] = len[7:0];
      h[17] = len[15:8];
      hcrc = 16'hffff;
      for (int i = 0; i < 18; i++) hcrc = ccitt_next(hcrc, h[i]);
      hcrc = ccitt_next(ccitt_next(hcrc, 8'h00), 8'h00);
      if (fault == FaultHdrCrc) hcrc = hcrc ^ (16'd1 << $urandom_range(15));
      h[18] = hcrc[7:0];
      h[19] = hcrc[15:8];
      if (fault == FaultMagic) begin
         do h[1] = 8'($urandom); while (h[1] == MagicByte);
      end
      for (int i = 0; i < 20; i++) pending_bytes.push_back(h[i]);
      if (fault == FaultMagic || fault == FaultHdrCrc || fault == FaultVersion ||
          fault == FaultLength) return;
      pcrc = 32'hffffffff;
      for (int i = 0; i < len; i++) begin
         b = (pat == PatZeros) ? 8'h00 : (pat == PatOnes) ? 8'hff : 8'($urandom);
         pcrc = ieee_next(pcrc, b);
         pending_bytes.push_back(b);
      end
      pcrc = ~pcrc;
      if (fault == FaultPldCrc) pcrc = pcrc ^ (32'd1 << $urandom_range(31));
      for (int i = 0; i < 4; i++) pending_bytes.push_back(pcrc[8 * i +: 8]);
   endtask

   task automatic add_random_frame();
      int f;
      logic [15:0] len;
      logic [7:0]  ver;
      f = ($urandom_range(99) < 70) ? FaultNone : $urandom_range(FaultLength, FaultMagic);
      len = ($urandom_range(9) == 0) ? 16'($urandom_range(64)) : 16'($urandom_range(8));
      if (len > cfg_max_len) len = cfg_max_len;
      ver = cfg_version;
      if (f == FaultVersion) ver = cfg_version ^ 8'(1 << $urandom_range(7));
      if (f == FaultLength) begin
         if (cfg_max_len == 16'hffff) f = FaultNone;
         else len = 16'($urandom_range(65535, cfg_max_len + 1));
      end
      add_frame(ver, len, f, PatRandom);
      repeat ($urandom_range(3)) pending_bytes.push_back(8'($urandom));
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || push || expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CsrVersion) cfg_version = value[7:0];
      else cfg_max_len = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int n;
      int prev_size;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hff);
      pending_bytes.push_back(MagicByte);
      add_frame(8'd1, 16'd0, FaultNone, PatZeros);
      add_frame(8'd1, 16'd1, FaultNone, PatOnes);
      add_frame(8'd1, 16'd2, FaultMagic, PatRandom);
      pending_bytes.push_back(StartByte);
      pending_bytes.push_back(StartByte);
      add_frame(8'd1, 16'd1, FaultHdrCrc, PatRandom);
      add_frame(8'd2, 16'd1, FaultNone, PatRandom);
      add_frame(8'd1, 16'd1025, FaultLength, PatRandom);
      add_frame(8'd1, 16'd3, FaultPldCrc, PatRandom);
      wait_drained();

      write_csr(CsrVersion, 16'd0);
      write_csr(CsrMaxLen, 16'd0);
      add_frame(8'd0, 16'd0, FaultNone, PatOnes);
      add_frame(8'd0, 16'd1, FaultNone, PatRandom);
      wait_drained();
      write_csr(CsrVersion, 16'd255);
      write_csr(CsrMaxLen, 16'hffff);
      add_frame(8'd255, 16'd5, FaultNone, PatOnes);
      wait_drained();

      for (int p = 0; p < 5; p++) begin
         case (p)
            0: begin write_csr(CsrVersion, 16'd1); write_csr(CsrMaxLen, 16'd1024); end
            1: begin write_csr(CsrVersion, 16'($urandom_range(255))); write_csr(CsrMaxLen, 16'd4); end
            2: begin write_csr(CsrVersion, 16'd255); write_csr(CsrMaxLen, 16'hffff); end
            3: begin write_csr(CsrVersion, 16'd0); write_csr(CsrMaxLen, 16'd40); end
            default: begin
               write_csr(CsrVersion, 16'($urandom_range(255)));
               write_csr(CsrMaxLen, 16'($urandom_range(64)));
            end
         endcase
         n = 0;
         while (n < 172) begin
            prev_size = pending_bytes.size();
            add_random_frame();
            n = n + pending_bytes.size() - prev_size;
            while (pending_bytes.size() > 8) @(posedge clock);
         end
         wait_drained();
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end
endmodule
